>>> rtl/sld_pkg.sv
// Shared types, constants and helper functions for the scaled level display.
// No dependencies; imported by sld_step, scaled_level_two_digit_display and the testbench.
package sld_pkg;

  localparam int unsigned SampleW = 10;
  localparam int unsigned LevelW  = 7;
  localparam int unsigned TickW   = 4;
  localparam int unsigned TpsW    = 5;
  localparam int unsigned CfgW    = 7;
  localparam int unsigned SegW    = 7;

  localparam logic [LevelW-1:0] LevelMax   = 7'd99;
  localparam logic [TpsW-1:0]   TpsReset   = 5'd8;
  localparam logic [LevelW-1:0] ScaleReset = 7'd70;
  localparam logic [16:0]       AdcHalf    = 17'd511;

  typedef enum logic [0:0] {
    REG_TICKS_PER_SAMPLE = 1'b0,
    REG_SCALE_TOP        = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [LevelW-1:0] level;
    logic [TickW-1:0]  tick;
    logic              phase;
  } sld_state_t;

  typedef struct packed {
    logic [TpsW-1:0]   ticks_per_sample;
    logic [LevelW-1:0] scale_top;
  } sld_cfg_t;

  typedef struct packed {
    logic [SegW-1:0]   segments;
    logic              high_digit_on;
    logic              low_digit_on;
    logic              start_conversion;
    logic              level_updated;
    logic [LevelW-1:0] new_level;
  } sld_result_t;

  // Segment pattern for one BCD digit, bit0 = a ... bit6 = g.
  function automatic logic [SegW-1:0] seg_code(input logic [3:0] digit);
    logic [SegW-1:0] code;
    case (digit)
      4'd0:    code = 7'h3F;
      4'd1:    code = 7'h06;
      4'd2:    code = 7'h5B;
      4'd3:    code = 7'h4F;
      4'd4:    code = 7'h66;
      4'd5:    code = 7'h6D;
      4'd6:    code = 7'h7D;
      4'd7:    code = 7'h07;
      4'd8:    code = 7'h7F;
      4'd9:    code = 7'h67;
      default: code = 7'h00;
    endcase
    return code;
  endfunction

  // Tens digit of a value 0..99: multiply by 205/2048.
  function automatic logic [3:0] tens_of(input logic [LevelW-1:0] lvl);
    logic [14:0] prod;
    prod = 15'(lvl) * 15'd205;
    return prod[14:11];
  endfunction

endpackage

>>> rtl/sld_step.sv
// One refresh tick of the scaled level display: digit drive, counter, rescale.
// Depends on sld_pkg for state, config and result types.
module sld_step (
  input  sld_pkg::sld_state_t            state_i,
  input  sld_pkg::sld_cfg_t              cfg_i,
  input  logic [sld_pkg::SampleW-1:0]    adc_sample_i,
  output sld_pkg::sld_state_t            state_d_o,
  output sld_pkg::sld_result_t           result_o
);
  import sld_pkg::*;

  logic [LevelW-1:0] lvl;
  logic [3:0]        tens;
  logic [LevelW-1:0] units_wide;
  logic [3:0]        digit;
  logic [TpsW-1:0]   tick_next;
  logic              fire;
  logic [16:0]       prod;
  logic [16:0]       biased;
  logic [17:0]       div_sum;
  logic [7:0]        quot;
  logic [LevelW-1:0] scaled;

  always_comb begin
    lvl        = (state_i.level > LevelMax) ? LevelMax : state_i.level;
    tens       = tens_of(lvl);
    units_wide = lvl - LevelW'(tens) * 7'd10;
    digit      = state_i.phase ? units_wide[3:0] : tens;

    // Divide by 1023 as (x + x/1024 + 1) / 1024; exact for every 17-bit x here.
    prod    = 17'(adc_sample_i) * 17'(cfg_i.scale_top);
    biased  = prod + AdcHalf;
    div_sum = 18'(biased) + 18'(biased[16:10]) + 18'd1;
    quot    = div_sum[17:10];
    scaled  = (quot > 8'(LevelMax)) ? LevelMax : quot[LevelW-1:0];

    tick_next = TpsW'(state_i.tick) + 5'd1;
    fire      = (tick_next == cfg_i.ticks_per_sample);

    state_d_o.phase = ~state_i.phase;
    state_d_o.tick  = fire ? '0 : tick_next[TickW-1:0];
    state_d_o.level = fire ? scaled : state_i.level;

    result_o.segments         = seg_code(digit);
    result_o.high_digit_on    = ~state_i.phase;
    result_o.low_digit_on     = state_i.phase;
    result_o.start_conversion = fire;
    result_o.level_updated    = fire;
    result_o.new_level        = state_d_o.level;
  end

endmodule

>>> rtl/scaled_level_two_digit_display.sv
// Top level of the scaled level two-digit display: handshakes, state, config.
// Depends on sld_pkg and sld_step.
//
//  Channel | Direction | Handshake             | Payload
//  --------+-----------+-----------------------+-------------------------------------
//  in      | input     | in_valid_i/in_stall_o | adc_sample_i
//  out     | output    | out_valid_o/out_stall_i | segments_o, high/low_digit_on_o,
//          |           |                       | start_conversion_o, level_updated_o,
//          |           |                       | new_level_o
//  cfg     | input     | cfg_we_i              | cfg_idx_i, cfg_data_i
//
// One tick per cycle sustained while the output does not stall; an input beat reaches
// the result beat through the input register, then the tick step into the result register.
// The step reads and writes the level, counter and digit phase in the same cycle,
// so consecutive ticks follow back to back.
// Reset clears the state: level 0, counter 0, tens digit first, registers 8 and 70.
// A stall on the output holds the result; the input register then holds too and
// in_stall_o rises only while it is full and cannot drain.
module scaled_level_two_digit_display (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [sld_pkg::SampleW-1:0]   adc_sample_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [sld_pkg::SegW-1:0]      segments_o,
  output logic                          high_digit_on_o,
  output logic                          low_digit_on_o,
  output logic                          start_conversion_o,
  output logic                          level_updated_o,
  output logic [sld_pkg::LevelW-1:0]    new_level_o,
  input  logic                          cfg_we_i,
  input  sld_pkg::cfg_reg_e             cfg_idx_i,
  input  logic [sld_pkg::CfgW-1:0]      cfg_data_i
);
  import sld_pkg::*;

  // Input stage: holds one accepted beat.
  logic               s1_valid_q;
  logic [SampleW-1:0] s1_sample_q;

  // Result stage.
  logic               out_valid_q;
  sld_result_t        result_q;

  // Tick state and configuration.
  sld_state_t         state_q, state_d;
  sld_cfg_t           cfg_q;
  sld_result_t        result_d;

  logic               out_free;
  logic               s1_advance;
  logic               in_accept;

  assign out_free   = ~out_valid_q | ~out_stall_i;
  assign s1_advance = s1_valid_q & out_free;
  // Input stage can take a beat when empty or draining this cycle.
  assign in_stall_o = s1_valid_q & ~out_free;
  assign in_accept  = in_valid_i & ~in_stall_o;

  sld_step u_step (
    .state_i      (state_q),
    .cfg_i        (cfg_q),
    .adc_sample_i (s1_sample_q),
    .state_d_o    (state_d),
    .result_o     (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
      cfg_q.ticks_per_sample <= TpsReset;
      cfg_q.scale_top        <= ScaleReset;
    end else begin
      // Advance the input stage.
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (s1_advance) begin
        s1_valid_q <= 1'b0;
      end
      // Advance the result stage.
      if (s1_advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      // Commit the tick state only when its result moves on.
      if (s1_advance) begin
        state_q <= state_d;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_TICKS_PER_SAMPLE: cfg_q.ticks_per_sample <= cfg_data_i[TpsW-1:0];
          REG_SCALE_TOP:        cfg_q.scale_top        <= cfg_data_i[LevelW-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_sample_q <= adc_sample_i;
    end
    if (s1_advance) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign segments_o         = result_q.segments;
  assign high_digit_on_o    = result_q.high_digit_on;
  assign low_digit_on_o     = result_q.low_digit_on;
  assign start_conversion_o = result_q.start_conversion;
  assign level_updated_o    = result_q.level_updated;
  assign new_level_o        = result_q.new_level;

  // Exactly one digit is enabled on every result beat.
  a_one_digit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (result_q.high_digit_on != result_q.low_digit_on))
    else $error("digit enables not exclusive");

  // Stored level stays in the display range.
  a_level_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.level <= LevelMax)
    else $error("stored level out of range");

  // Each tick that moves on flips the digit phase.
  a_phase_toggle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_advance |=> (state_q.phase != $past(state_q.phase)))
    else $error("digit phase did not toggle");

  // The input side stalls only when its stage is full and blocked.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q && out_stall_i))
    else $error("spurious input stall");

  // A level update always comes with a conversion request and a counter restart.
  a_fire_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_advance && result_d.level_updated) |=>
      (state_q.tick == '0 && result_q.start_conversion))
    else $error("update without counter restart");

endmodule

>>> tb/sv/scaled_level_two_digit_display_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for the scaled level two-digit display block.
// Depends on sld_pkg and scaled_level_two_digit_display; a directed table then random phases.
module scaled_level_two_digit_display_test;
  import sld_pkg::*;

  // Clock, reset and block ports
  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [SampleW-1:0]   adc_sample_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [SegW-1:0]      segments_o;
  logic                 high_digit_on_o;
  logic                 low_digit_on_o;
  logic                 start_conversion_o;
  logic                 level_updated_o;
  logic [LevelW-1:0]    new_level_o;
  logic                 cfg_we_i = 1'b0;
  cfg_reg_e             cfg_idx_i = REG_TICKS_PER_SAMPLE;
  logic [CfgW-1:0]      cfg_data_i = '0;

  localparam int unsigned TICK_TARGET = 1850;

  // One directed step: either a register write or a tick, with an optional
  // hand-written expectation.
  typedef struct {
    bit                 is_write;
    cfg_reg_e           reg_idx;
    logic [CfgW-1:0]    reg_data;
    logic [SampleW-1:0] adc;
    bit                 has_fixed;
    sld_result_t        fixed;
  } plan_row_t;

  plan_row_t   plan [0:39];
  int          plan_len;

  // Display model: shadow registers and state
  logic [TpsW-1:0]   shadow_tps;
  logic [LevelW-1:0] shadow_scale;
  logic [LevelW-1:0] disp_level;
  logic [TickW-1:0]  disp_tick;
  logic              disp_phase;
  logic [SegW-1:0]   glyph [0:9];

  sld_result_t pending_display [$];
  int unsigned ticks_sent;
  int unsigned beats_seen;
  int unsigned fault_count;

  scaled_level_two_digit_display dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .adc_sample_i       (adc_sample_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .segments_o         (segments_o),
    .high_digit_on_o    (high_digit_on_o),
    .low_digit_on_o     (low_digit_on_o),
    .start_conversion_o (start_conversion_o),
    .level_updated_o    (level_updated_o),
    .new_level_o        (new_level_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_idx_i          (cfg_idx_i),
    .cfg_data_i         (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Hard stop in case a handshake hangs.
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // Advance the display model by one tick and return what the block should show.
  function automatic sld_result_t step_display(input logic [SampleW-1:0] adc);
    sld_result_t       res;
    logic [TpsW-1:0]   next_count;
    int unsigned       scaled;
    logic              fire;
    // Drive the digit from the level held before this tick.
    if (!disp_phase) begin
      res.segments      = glyph[disp_level / 10];
      res.high_digit_on = 1'b1;
      res.low_digit_on  = 1'b0;
    end else begin
      res.segments      = glyph[disp_level % 10];
      res.high_digit_on = 1'b0;
      res.low_digit_on  = 1'b1;
    end
    disp_phase = ~disp_phase;
    // The counter is compared plus one against the 5-bit register, so a
    // period of zero or above sixteen never matches.
    next_count = {1'b0, disp_tick} + 5'd1;
    fire = (next_count == shadow_tps);
    if (fire) begin
      scaled = (int'(adc) * int'(shadow_scale) + 511) / 1023;
      if (scaled > 99) scaled = 99;
      disp_level = LevelW'(scaled);
      disp_tick  = '0;
    end else begin
      disp_tick = next_count[TickW-1:0];
    end
    res.start_conversion = fire;
    res.level_updated    = fire;
    res.new_level        = disp_level;
    return res;
  endfunction

  function automatic void add_tick(input logic [SampleW-1:0] adc);
    plan[plan_len] = '{1'b0, REG_TICKS_PER_SAMPLE, '0, adc, 1'b0, '0};
    plan_len++;
  endfunction

  function automatic void add_fixed(input logic [SampleW-1:0] adc, input sld_result_t res);
    plan[plan_len] = '{1'b0, REG_TICKS_PER_SAMPLE, '0, adc, 1'b1, res};
    plan_len++;
  endfunction

  function automatic void add_write(input cfg_reg_e idx, input logic [CfgW-1:0] data);
    plan[plan_len] = '{1'b1, idx, data, '0, 1'b0, '0};
    plan_len++;
  endfunction

  function automatic logic [SampleW-1:0] pick_adc();
    int unsigned roll;
    roll = $urandom_range(9);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return SampleW'($urandom_range(1023));
  endfunction

  // Sender idles at random, except for a stretch of back-to-back beats.
  function automatic bit sender_idles();
    if (ticks_sent >= 900 && ticks_sent < 1200) return 1'b0;
    return $urandom_range(99) < 8;
  endfunction

  // Offer one tick; called and left at a falling edge. Valid stays high on
  // return so a following tick does not drop and raise it in one step.
  task automatic send_tick(input logic [SampleW-1:0] adc, input bit has_fixed,
                           input sld_result_t fixed);
    sld_result_t predicted;
    while (sender_idles()) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    adc_sample_i <= adc;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = step_display(adc);
    pending_display.push_back(has_fixed ? fixed : predicted);
    ticks_sent++;
    @(negedge clk_i);
  endtask

  // Write one register once every result is back. Called with valid low.
  task automatic write_reg(input cfg_reg_e idx, input logic [CfgW-1:0] data);
    while (pending_display.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_TICKS_PER_SAMPLE) shadow_tps = data[TpsW-1:0];
    else shadow_scale = data;
  endtask

  // Receiver: random stalls, one long hold-off once traffic is flowing, and
  // a calm stretch without stalls.
  initial begin : receiver
    bit held;
    int unsigned hold_cycles;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && beats_seen >= 400) begin
        // Hold off long enough for the input register to fill and stall.
        held = 1'b1;
        out_stall_i <= 1'b1;
        for (hold_cycles = 1; hold_cycles < 64; hold_cycles++) @(negedge clk_i);
      end else if (beats_seen >= 900 && beats_seen < 1200) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < 8);
      end
    end
  end

  // Compare each result beat against the oldest expectation.
  always @(posedge clk_i) begin : check_beat
    sld_result_t got;
    sld_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      beats_seen++;
      got = '{segments_o, high_digit_on_o, low_digit_on_o, start_conversion_o,
              level_updated_o, new_level_o};
      if (pending_display.size() == 0) begin
        fault_count++;
        if (fault_count <= 10)
          $display("unexpected beat %0d: seg=%h hi=%b lo=%b start=%b upd=%b lvl=%0d",
                   beats_seen, got.segments, got.high_digit_on, got.low_digit_on,
                   got.start_conversion, got.level_updated, got.new_level);
      end else begin
        want = pending_display.pop_front();
        if (got.segments !== want.segments || got.high_digit_on !== want.high_digit_on ||
            got.low_digit_on !== want.low_digit_on ||
            got.start_conversion !== want.start_conversion ||
            got.level_updated !== want.level_updated || got.new_level !== want.new_level) begin
          fault_count++;
          if (fault_count <= 10)
            $display("beat %0d mismatch: exp seg=%h hi=%b lo=%b start=%b upd=%b lvl=%0d, %s",
                     beats_seen, want.segments, want.high_digit_on, want.low_digit_on,
                     want.start_conversion, want.level_updated, want.new_level,
                     $sformatf("got seg=%h hi=%b lo=%b start=%b upd=%b lvl=%0d",
                               got.segments, got.high_digit_on, got.low_digit_on,
                               got.start_conversion, got.level_updated, got.new_level));
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned row;
    int unsigned span;
    int unsigned roll;
    logic [TpsW-1:0]   tps;
    logic [LevelW-1:0] scale;
    glyph = '{7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h67};
    shadow_tps   = 5'd8;
    shadow_scale = 7'd70;
    disp_level   = '0;
    disp_tick    = '0;
    disp_phase   = 1'b0;
    ticks_sent   = 0;
    beats_seen   = 0;
    fault_count  = 0;
    plan_len     = 0;

    // Directed table. Fixed rows: the state right after reset, then a
    // saturating full-scale update and a one-tick period.
    add_fixed(10'h3FF, '{7'h3F, 1'b1, 1'b0, 1'b0, 1'b0, 7'd0});
    add_fixed(10'h000, '{7'h3F, 1'b0, 1'b1, 1'b0, 1'b0, 7'd0});
    add_write(REG_SCALE_TOP, 7'd127);         // scale above range
    add_write(REG_TICKS_PER_SAMPLE, 7'd3);    // lowered mid-count, fires next tick
    add_fixed(10'h3FF, '{7'h3F, 1'b1, 1'b0, 1'b1, 1'b1, 7'd99});
    add_write(REG_TICKS_PER_SAMPLE, 7'd1);
    add_write(REG_SCALE_TOP, 7'd99);
    add_fixed(10'h3FF, '{7'h67, 1'b0, 1'b1, 1'b1, 1'b1, 7'd99});
    add_fixed(10'h000, '{7'h67, 1'b1, 1'b0, 1'b1, 1'b1, 7'd0});
    add_tick(10'd517);
    add_tick(10'd1);
    add_tick(10'd682);
    add_write(REG_SCALE_TOP, 7'd0);
    add_tick(10'h3FF);
    add_tick(10'd341);
    add_write(REG_TICKS_PER_SAMPLE, 7'd0);    // period zero: never fires
    add_tick(10'h3FF);
    add_tick(10'h2AA);
    add_write(REG_TICKS_PER_SAMPLE, 7'h7F);   // upper data bits dropped, period 31
    add_tick(10'h155);
    add_tick(10'h000);
    add_write(REG_TICKS_PER_SAMPLE, 7'd17);
    add_tick(10'h3FF);
    add_write(REG_TICKS_PER_SAMPLE, 7'd16);
    add_write(REG_SCALE_TOP, 7'd99);
    add_tick(10'h3FF);
    add_tick(10'd900);

    // Hold reset, then release at a falling edge.
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (row = 0; row < plan_len; row++) begin
      if (plan[row].is_write) begin
        in_valid_i <= 1'b0;
        write_reg(plan[row].reg_idx, plan[row].reg_data);
      end else begin
        send_tick(plan[row].adc, plan[row].has_fixed, plan[row].fixed);
      end
    end

    // Random phases: retune both registers (sometimes one) while idle, then
    // stream a burst of ticks.
    while (ticks_sent < TICK_TARGET) begin
      in_valid_i <= 1'b0;
      roll = $urandom_range(9);
      case (roll)
        0:       tps = 5'd0;
        1:       tps = 5'($urandom_range(31, 17));
        2:       tps = 5'd16;
        3:       tps = 5'd1;
        default: tps = 5'($urandom_range(16, 1));
      endcase
      roll = $urandom_range(9);
      case (roll)
        0:       scale = 7'd0;
        1:       scale = 7'd99;
        2:       scale = 7'd127;
        3:       scale = 7'($urandom_range(127, 100));
        default: scale = 7'($urandom_range(99));
      endcase
      roll = $urandom_range(5);
      if (roll != 0)
        write_reg(REG_TICKS_PER_SAMPLE, {2'($urandom_range(3)), tps});
      if (roll != 1)
        write_reg(REG_SCALE_TOP, scale);
      span = $urandom_range(200, 40);
      while (span != 0 && ticks_sent < TICK_TARGET) begin
        send_tick(pick_adc(), 1'b0, '0);
        span--;
      end
    end

    // Drain, then let the pipeline settle.
    in_valid_i <= 1'b0;
    while (pending_display.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (fault_count == 0 && pending_display.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
